// ===== rtl/core/utf8vd_pkg.sv =====
package utf8vd_pkg;

    localparam int BYTE_W            = 8;
    localparam int CP_W              = 31;
    localparam int PEND_W            = 3;
    localparam int ONES_W            = 4;
    localparam int CONT_BITS         = 6;
    localparam int MAX_SEQ_BYTES_DEF = 6;

    // Leading-one classes of a byte
    localparam logic [ONES_W-1:0] CLASS_SINGLE = 4'd0;
    localparam logic [ONES_W-1:0] CLASS_CONT   = 4'd1;

    // Payload mask of a lead byte, shifted right by its leading-one count
    localparam logic [BYTE_W-1:0] LEAD_MASK = 8'h7F;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            text_end;
    } dec_result_t;

    typedef struct packed {
        logic head_valid;
        logic skid_valid;
    } buf_status_t;

    // Count leading one bits, MSB first
    function automatic logic [ONES_W-1:0] leading_ones(input logic [BYTE_W-1:0] b);
        logic [ONES_W-1:0] n;
        logic              run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (run && b[i])
                n = n + 4'd1;
            else
                run = 1'b0;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/utf8vd_decode.sv =====
module utf8vd_decode #(
    parameter int MAX_SEQUENCE_BYTES = utf8vd_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic [utf8vd_pkg::BYTE_W-1:0]        text_byte,
    input  logic                                 final_byte,
    output utf8vd_pkg::dec_result_t              result
);
    import utf8vd_pkg::*;

    logic [PEND_W-1:0] bytes_pending_reg, bytes_pending_next;
    logic [CP_W-1:0]   partial_value_reg, partial_value_next;
    logic              discarding_reg,    discarding_next;

    logic [ONES_W-1:0] ones;
    logic [CP_W-1:0]   shifted_value;
    logic [PEND_W-1:0] pending_less;
    logic [BYTE_W-1:0] lead_bits;
    logic              raise_err;

    assign ones          = leading_ones(text_byte);
    assign shifted_value = {partial_value_reg[CP_W-CONT_BITS-1:0], text_byte[CONT_BITS-1:0]};
    assign pending_less  = bytes_pending_reg - 3'd1;
    assign lead_bits     = text_byte & (LEAD_MASK >> ones);

    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        partial_value_next = partial_value_reg;
        discarding_next    = discarding_reg;
        raise_err          = 1'b0;
        result.valid       = 1'b0;
        result.code_point  = '0;
        result.is_error    = 1'b0;
        result.text_end    = final_byte;

        if (discarding_reg)
        begin
            if (final_byte)
                discarding_next = 1'b0;
        end
        else if (bytes_pending_reg != '0)
        begin
            if (ones != CLASS_CONT)
                raise_err = 1'b1;
            else if (pending_less == '0)
            begin
                result.valid       = 1'b1;
                result.code_point  = shifted_value;
                bytes_pending_next = '0;
                partial_value_next = '0;
            end
            else if (final_byte)
                raise_err = 1'b1;
            else
            begin
                bytes_pending_next = pending_less;
                partial_value_next = shifted_value;
            end
        end
        else if (ones == CLASS_SINGLE)
        begin
            result.valid      = 1'b1;
            result.code_point = {{(CP_W-BYTE_W){1'b0}}, text_byte};
        end
        else if (ones == CLASS_CONT || ones > ONES_W'(MAX_SEQUENCE_BYTES) || final_byte)
            raise_err = 1'b1;
        else
        begin
            partial_value_next = {{(CP_W-BYTE_W){1'b0}}, lead_bits};
            bytes_pending_next = PEND_W'(ones - 4'd1);
        end

        // Drop the open sequence; skip to the end of the text unless this is it
        if (raise_err)
        begin
            bytes_pending_next = '0;
            partial_value_next = '0;
            discarding_next    = !final_byte;
            result.valid       = 1'b1;
            result.is_error    = 1'b1;
            result.code_point  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_pending_reg <= '0;
            partial_value_reg <= '0;
            discarding_reg    <= 1'b0;
        end
        else if (go)
        begin
            bytes_pending_reg <= bytes_pending_next;
            partial_value_reg <= partial_value_next;
            discarding_reg    <= discarding_next;
        end
    end

endmodule

// ===== rtl/core/utf8vd_out_buf.sv =====
module utf8vd_out_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  utf8vd_pkg::dec_result_t       push_data,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [utf8vd_pkg::CP_W-1:0]   code_point,
    output logic                          is_error,
    output logic                          text_end,
    output utf8vd_pkg::buf_status_t       status
);
    import utf8vd_pkg::*;

    logic            head_valid_reg;
    logic            skid_valid_reg;
    logic [CP_W-1:0] head_cp_reg,  skid_cp_reg;
    logic            head_err_reg, skid_err_reg;
    logic            head_end_reg, skid_end_reg;
    logic            pop;

    assign pop = head_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
                head_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_cp_reg  <= skid_cp_reg;
                head_err_reg <= skid_err_reg;
                head_end_reg <= skid_end_reg;
                skid_cp_reg  <= push_data.code_point;
                skid_err_reg <= push_data.is_error;
                skid_end_reg <= push_data.text_end;
            end
            else
            begin
                head_cp_reg  <= push_data.code_point;
                head_err_reg <= push_data.is_error;
                head_end_reg <= push_data.text_end;
            end
        end
        else if (push)
        begin
            skid_cp_reg  <= push_data.code_point;
            skid_err_reg <= push_data.is_error;
            skid_end_reg <= push_data.text_end;
        end
    end

    assign out_valid         = head_valid_reg;
    assign code_point        = head_cp_reg;
    assign is_error          = head_err_reg;
    assign text_end          = head_end_reg;
    assign status.head_valid = head_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

// ===== rtl/core/utf8_validating_decoder_core.sv =====
// Byte-serial UTF-8 decoder in the original (up to six byte) form. Feed one
// byte per beat on the input channel with final_byte set on the last byte of
// each text; a result beat carries a 31-bit code point, or is_error with a
// zero code point, and text_end copies final_byte of the byte that caused it.
// Lead bytes with more leading ones than MAX_SEQUENCE_BYTES, 0xFE, 0xFF, stray
// continuation bytes, a non-continuation inside a sequence, and a text that
// ends mid-sequence each give one error beat; after an error that is not on
// a final byte, the rest of the text through its final byte is dropped with
// no results. Overlong and surrogate values are passed through unchecked and
// byte 0x00 decodes as U+0000. One byte is taken every clock cycle while
// in_stall is low: the byte lands in an input register, is decoded against
// the sequence state in one short combinational step, and its result (if
// any) is registered into a two-entry output queue whose head drives the
// result beat. in_stall rises only when the output queue is full and a byte
// waits in the input register, i.e. after the consumer has held out_stall
// for two results.
module utf8_validating_decoder_core #(
    parameter int MAX_SEQUENCE_BYTES = utf8vd_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [utf8vd_pkg::BYTE_W-1:0]   text_byte,
    input  logic                            final_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [utf8vd_pkg::CP_W-1:0]     code_point,
    output logic                            is_error,
    output logic                            text_end
);
    import utf8vd_pkg::*;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_final_reg;
    logic              in_accept;
    logic              s1_go;
    dec_result_t       dec_res;
    buf_status_t       buf_status;

    // Advance the held byte whenever the result queue has a free entry
    assign s1_go     = s1_valid_reg && !buf_status.skid_valid;
    assign in_stall  = s1_valid_reg && buf_status.skid_valid;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= text_byte;
            s1_final_reg <= final_byte;
        end
    end

    utf8vd_decode #(
        .MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s1_go),
        .text_byte (s1_byte_reg),
        .final_byte(s1_final_reg),
        .result    (dec_res)
    );

    // Only bytes that complete a character or hit an error push a result
    utf8vd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_go && dec_res.valid),
        .push_data (dec_res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .code_point(code_point),
        .is_error  (is_error),
        .text_end  (text_end),
        .status    (buf_status)
    );

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid |-> buf_status.head_valid)
        else $error("result queue skid entry held with empty head");

    a_error_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_res.valid && dec_res.is_error) |-> (dec_res.code_point == '0))
        else $error("error result carries a nonzero code point");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted byte lost from input register");
`endif

endmodule

// ===== verif/tb_utf8_validating_decoder_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the byte-serial UTF-8 decoder.
module tb_utf8_validating_decoder_core;
    import utf8vd_pkg::*;

    localparam int MAX_SEQ        = MAX_SEQ_BYTES_DEF;
    localparam int TOTAL_BEATS    = 975;   // directed beats plus about 950 random ones
    localparam int IDLE_LIMIT     = 2000;  // cycles with no handshake before giving up
    localparam int HOLDOFF_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 8;     // a result passes the input register and the output queue
    localparam int MAX_REPORTS    = 40;

    // Byte tags of the UTF-8 coding
    localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD = 8'h3F;
    localparam logic [BYTE_W-1:0] ASCII_MAX    = 8'h7F;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              hold_for_drain;  // sender waits for all results first
    } text_beat_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            text_end;
    } char_result_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] text_byte  = '0;
    logic              final_byte = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic              is_error;
    logic              text_end;

    // Stimulus and expectation stores
    text_beat_t   pending_beats[$];
    char_result_t expected_chars[$];

    // Shadow decoder state
    logic [PEND_W-1:0] seq_left    = '0;
    logic [CP_W-1:0]   seq_value   = '0;
    bit                skip_to_end = 1'b0;

    bit in_beat_taken  = 1'b0;
    int bytes_taken    = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    // Sender burst/gap control
    int send_burst = 1;
    int send_gap   = 0;

    // Receiver stall pattern control
    int stall_mode     = 0;
    int stall_phase    = 0;
    int holdoff_left   = 0;
    int holdoffs_done  = 0;

    utf8_validating_decoder_core #(
        .MAX_SEQUENCE_BYTES(MAX_SEQ)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .is_error   (is_error),
        .text_end   (text_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count the run of leading one bits, MSB first.
    function automatic logic [ONES_W-1:0] count_lead_ones(input logic [BYTE_W-1:0] b);
        logic [ONES_W-1:0] n;
        casez (b)
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    // Advance the shadow decoder by one accepted byte and queue the
    // character or error that it yields, if any.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [ONES_W-1:0] n;
        char_result_t      r;
        bit                bad;
        bit                emit;
        n            = count_lead_ones(b);
        r.code_point = '0;
        r.is_error   = 1'b0;
        r.text_end   = fin;
        bad          = 1'b0;
        emit         = 1'b0;
        if (skip_to_end)
        begin
            // Drop the rest of a broken text; its final byte ends the skip.
            if (fin)
                skip_to_end = 1'b0;
            return;
        end
        if (seq_left != '0)
        begin
            if (n != CLASS_CONT)
                bad = 1'b1;
            else
            begin
                seq_value = {seq_value[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
                seq_left  = seq_left - 1'b1;
                if (seq_left == '0)
                begin
                    r.code_point = seq_value;
                    seq_value    = '0;
                    emit         = 1'b1;
                end
                else if (fin)
                    bad = 1'b1;  // text ends before the sequence completes
            end
        end
        else if (n == CLASS_SINGLE)
        begin
            r.code_point = CP_W'(b);
            emit         = 1'b1;
        end
        else if (n == CLASS_CONT || n > MAX_SEQ || fin)
            bad = 1'b1;  // stray continuation, bad lead, or lead on the last byte
        else
        begin
            seq_value = CP_W'(b & (LEAD_MASK >> n));
            seq_left  = PEND_W'(n - 4'd1);
        end
        if (bad)
        begin
            seq_left     = '0;
            seq_value    = '0;
            skip_to_end  = !fin;
            r.code_point = '0;
            r.is_error   = 1'b1;
            emit         = 1'b1;
        end
        if (emit)
            expected_chars.push_back(r);
    endfunction

    task automatic push_beat(input logic [BYTE_W-1:0] b, input logic fin, input bit drain);
        text_beat_t beat;
        beat.value          = b;
        beat.last           = fin;
        beat.hold_for_drain = drain;
        pending_beats.push_back(beat);
    endtask

    // Queue one random text: mostly well-formed characters of 1 to 6 bytes,
    // some raw noise, and some texts broken in one of several ways.
    task automatic queue_random_text(input bit drain);
        logic [BYTE_W-1:0] bytes[$];
        logic [BYTE_W-1:0] b;
        int                kind;
        int                sel;
        int                len;
        int                last_len;
        kind     = $urandom_range(0, 99);
        last_len = 1;
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 8))
                bytes.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                // Favor short characters; long ones still show up regularly.
                sel = $urandom_range(0, 15);
                len = (sel < 6) ? 1 : (sel < 10) ? 2 : (sel < 13) ? 3 : sel - 9;
                last_len = len;
                if (len == 1)
                    bytes.push_back(8'($urandom) & ASCII_MAX);
                else
                begin
                    bytes.push_back(~(8'hFF >> len) | (8'($urandom) & (LEAD_MASK >> len)));
                    repeat (len - 1)
                        bytes.push_back(CONT_TAG | (8'($urandom) & CONT_PAYLOAD));
                end
            end
            if (kind >= 75)
            begin
                case ($urandom_range(0, 3))
                    0:  // bad lead byte (0xFE or 0xFF) somewhere in the text
                        bytes.insert($urandom_range(0, bytes.size()),
                                     8'hFE | 8'($urandom_range(0, 1)));
                    1:  // continuation byte dropped in at a random place
                        bytes.insert($urandom_range(0, bytes.size()),
                                     CONT_TAG | (8'($urandom) & CONT_PAYLOAD));
                    2:  // text ends inside a sequence
                        if (last_len > 1)
                            void'(bytes.pop_back());
                        else
                        begin
                            len = $urandom_range(2, 6);
                            bytes.push_back(~(8'hFF >> len) |
                                            (8'($urandom) & (LEAD_MASK >> len)));
                            repeat ($urandom_range(0, len - 2))
                                bytes.push_back(CONT_TAG | (8'($urandom) & CONT_PAYLOAD));
                        end
                    default:  // overwrite a byte with a non-continuation
                    begin
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10)
                            b[6] = 1'b1;
                        bytes[$urandom_range(0, bytes.size() - 1)] = b;
                    end
                endcase
            end
        end
        foreach (bytes[i])
            push_beat(bytes[i], i == bytes.size() - 1, drain && i == 0);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Input driver: change the beat at the falling edge. Hold a beat that
    // has not been taken yet; otherwise load the next one, or idle during a
    // gap between bursts. A beat marked hold_for_drain waits until every
    // expected result has come back.
    always @(negedge clk)
    begin : drive_bytes
        logic next_valid;
        next_valid = in_valid;
        if (!rst_n)
            next_valid = 1'b0;
        else if (!in_valid || in_beat_taken)
        begin
            next_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].hold_for_drain && expected_chars.size() != 0))
            begin
                text_byte  <= pending_beats[0].value;
                final_byte <= pending_beats[0].last;
                void'(pending_beats.pop_front());
                next_valid = 1'b1;
                if (send_burst > 1)
                    send_burst--;
                else
                begin
                    // End of burst: pick the next one and the gap before it;
                    // a zero gap chains bursts into long unbroken stretches.
                    send_burst = $urandom_range(1, 24);
                    send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: stall on a random pattern whose mode is redrawn whenever
    // stall_phase wraps, plus two long hold-offs while the sender keeps offering
    // beats, so the output queue fills and the block has to stall its input.
    always @(negedge clk)
    begin : drive_stall
        logic next_stall;
        next_stall = 1'b0;
        if (holdoff_left == 0 && holdoffs_done < 2 &&
            bytes_taken >= 200 + 450 * holdoffs_done)
        begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoffs_done++;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            next_stall = 1'b1;
        end
        else
        begin
            if (stall_phase == 0)
                stall_mode = $urandom_range(0, 3);
            stall_phase = (stall_phase + 1) % 50;
            case (stall_mode)
                0:       next_stall = 1'b0;
                1:       next_stall = ($urandom_range(0, 3) == 0);
                2:       next_stall = ($urandom_range(0, 3) != 0);
                default: next_stall = !out_stall;
            endcase
        end
        out_stall <= next_stall;
    end

    // Input monitor: run every accepted beat through the shadow decoder.
    always @(posedge clk)
    begin
        in_beat_taken = rst_n && in_valid && !in_stall;
        if (in_beat_taken)
        begin
            decode_byte(text_byte, final_byte);
            bytes_taken++;
        end
    end

    // Output monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_chars
        char_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("result with none expected: cp=%h err=%b end=%b",
                                          code_point, is_error, text_end));
            else
            begin
                want = expected_chars.pop_front();
                if (code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              code_point, want.code_point));
                if (is_error !== want.is_error)
                    report_mismatch($sformatf("is_error %b, expected %b",
                                              is_error, want.is_error));
                if (text_end !== want.text_end)
                    report_mismatch($sformatf("text_end %b, expected %b",
                                              text_end, want.text_end));
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[utf8_validating_decoder_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        bit drain;
        // U+0000 and the top of the single-byte range
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'h7F, 1'b1, 1'b0);
        // Largest two-byte value
        push_beat(8'hDF, 1'b0, 1'b0);
        push_beat(8'hBF, 1'b1, 1'b0);
        // Largest six-byte value, all 31 bits set
        push_beat(8'hFD, 1'b0, 1'b0);
        repeat (4)
            push_beat(8'hBF, 1'b0, 1'b0);
        push_beat(8'hBF, 1'b1, 1'b0);
        // Bad lead mid-text, then the rest of the text is dropped
        push_beat(8'hFE, 1'b0, 1'b0);
        push_beat(8'h41, 1'b0, 1'b0);
        push_beat(8'h42, 1'b1, 1'b0);
        // Bad lead on the final byte: no skipping afterwards
        push_beat(8'hFF, 1'b1, 1'b0);
        // Stray continuation byte
        push_beat(8'h80, 1'b1, 1'b0);
        // Non-continuation inside a sequence, then skip to the end of text
        push_beat(8'hE2, 1'b0, 1'b0);
        push_beat(8'h41, 1'b0, 1'b0);
        push_beat(8'h30, 1'b1, 1'b0);
        // Text ends on a lead byte, then on a continuation byte
        push_beat(8'hC3, 1'b1, 1'b0);
        push_beat(8'hE2, 1'b0, 1'b0);
        push_beat(8'h82, 1'b1, 1'b0);

        // Random texts; the first one and a few later ones make the sender
        // pause until every outstanding result has drained.
        drain = 1'b1;
        while (pending_beats.size() < TOTAL_BEATS)
        begin
            queue_random_text(drain);
            drain = ($urandom_range(0, 39) == 0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last beat to be taken, then for the last result.
        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[utf8_validating_decoder_core] OK");
        else
            $display("[utf8_validating_decoder_core] ERROR");
        $finish;
    end

endmodule
